### rtl/utv_pkg.sv
// Shared types and constants for the UTF-8 text validator.
package utv_pkg;

  // Configuration register indexes
  localparam int unsigned CfgNum      = 2;
  localparam int unsigned CfgIdxW     = 1;
  localparam logic [CfgIdxW-1:0] CFG_SPACE_EN = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_TAB_EN   = 1'd1;

  // Field widths
  localparam int unsigned ByteW = 8;
  localparam int unsigned CpW   = 21;

  // Byte values and code point bounds
  localparam logic [ByteW-1:0] BYTE_NUL   = 8'h00;
  localparam logic [ByteW-1:0] BYTE_TAB   = 8'h09;
  localparam logic [ByteW-1:0] BYTE_SPACE = 8'h20;
  localparam logic [ByteW-1:0] BYTE_DEL   = 8'h7F;
  localparam logic [CpW-1:0] CP_MIN_3B    = 21'h000800;
  localparam logic [CpW-1:0] CP_MIN_4B    = 21'h010000;
  localparam logic [CpW-1:0] CP_SURR_LO   = 21'h00D800;
  localparam logic [CpW-1:0] CP_SURR_HI   = 21'h00DFFF;
  localparam logic [CpW-1:0] CP_MAX       = 21'h10FFFF;

  // Verdict codes
  typedef enum logic [1:0] {
    VERDICT_OPEN    = 2'd0,
    VERDICT_VALID   = 2'd1,
    VERDICT_INVALID = 2'd2
  } verdict_e;

  // Sequence tracking state
  typedef struct packed {
    logic [1:0]     pending;
    logic [2:0]     seq_len;
    logic [CpW-1:0] cp;
    logic           err;
  } seq_state_t;

  // Result of one item
  typedef struct packed {
    verdict_e verdict;
    logic     error_seen;
  } result_t;

endpackage

### rtl/utv_step.sv
// Per-byte decode: next sequence state and result for one item.
module utv_step (
  input  utv_pkg::seq_state_t        cur_i,
  input  logic [utv_pkg::ByteW-1:0]  byte_i,
  input  logic                       last_i,
  input  logic                       space_en_i,
  input  logic                       tab_en_i,
  output utv_pkg::seq_state_t        nxt_o,
  output utv_pkg::result_t           res_o
);

  utv_pkg::seq_state_t       s;
  logic [utv_pkg::CpW-1:0]   cp_shift;
  logic [1:0]                pend_dec;
  logic                      lead_ctrl_bad;
  logic                      cp_bad;

  // Shift the six payload bits of a continuation byte into the code point
  assign cp_shift = {cur_i.cp[utv_pkg::CpW-7:0], byte_i[5:0]};
  assign pend_dec = cur_i.pending - 2'd1;

  // Control and disallowed characters at lead position
  assign lead_ctrl_bad = (byte_i == utv_pkg::BYTE_NUL) || (byte_i == utv_pkg::BYTE_DEL) ||
                         ((byte_i < utv_pkg::BYTE_SPACE) &&
                          !(tab_en_i && (byte_i == utv_pkg::BYTE_TAB))) ||
                         (!space_en_i && (byte_i == utv_pkg::BYTE_SPACE));

  // Overlong, surrogate and range checks on a completed sequence
  assign cp_bad = ((cur_i.seq_len == 3'd3) && (cp_shift < utv_pkg::CP_MIN_3B)) ||
                  ((cur_i.seq_len == 3'd4) && (cp_shift < utv_pkg::CP_MIN_4B)) ||
                  ((cp_shift >= utv_pkg::CP_SURR_LO) && (cp_shift <= utv_pkg::CP_SURR_HI)) ||
                  (cp_shift > utv_pkg::CP_MAX);

  always_comb begin
    s = cur_i;
    // Advance the sequence unless an error is already latched
    if (!cur_i.err) begin
      if (cur_i.pending == 2'd0) begin
        s.pending = 2'd0;
        s.seq_len = 3'd0;
        s.cp      = '0;
        if (lead_ctrl_bad) begin
          s.err = 1'b1;
        end else if (!byte_i[7]) begin
          s.err = 1'b0;
        end else if (byte_i[7:5] == 3'b110) begin
          if (byte_i[4:1] == 4'd0) begin
            s.err = 1'b1;
          end else begin
            s.seq_len = 3'd2;
            s.pending = 2'd1;
            s.cp      = {16'd0, byte_i[4:0]};
          end
        end else if (byte_i[7:4] == 4'b1110) begin
          s.seq_len = 3'd3;
          s.pending = 2'd2;
          s.cp      = {17'd0, byte_i[3:0]};
        end else if (byte_i[7:3] == 5'b11110) begin
          s.seq_len = 3'd4;
          s.pending = 2'd3;
          s.cp      = {18'd0, byte_i[2:0]};
        end else begin
          s.err = 1'b1;
        end
      end else begin
        if (byte_i[7:6] != 2'b10) begin
          s.err     = 1'b1;
          s.pending = 2'd0;
          s.seq_len = 3'd0;
          s.cp      = '0;
        end else if (pend_dec != 2'd0) begin
          s.pending = pend_dec;
          s.cp      = cp_shift;
        end else begin
          s.err     = cp_bad;
          s.pending = 2'd0;
          s.seq_len = 3'd0;
          s.cp      = '0;
        end
      end
    end

    // Close the string on its last byte; a cut-short sequence is an error
    if (last_i) begin
      res_o.error_seen = s.err || (s.pending != 2'd0);
      res_o.verdict    = res_o.error_seen ? utv_pkg::VERDICT_INVALID
                                          : utv_pkg::VERDICT_VALID;
      nxt_o            = '0;
    end else begin
      res_o.error_seen = s.err;
      res_o.verdict    = utv_pkg::VERDICT_OPEN;
      nxt_o            = s;
    end
  end

endmodule

### rtl/utf8_text_validator_core.sv
// Top level of the UTF-8 text validator: state, config and result register.
//
// Checks a byte stream, one string at a time, for well-formed UTF-8 text
// without control characters. Each input item on s_axis carries one byte in
// tdata and marks the final byte of a string with tlast. Every input item
// gives exactly one result item on m_axis: verdict open (0) for inner bytes,
// valid (1) or invalid (2) on the last byte, plus the running error flag.
// The result of an accepted item is registered and shown in the cycle after
// acceptance. Throughput is one item per cycle while the receiver keeps
// taking results; the sequence state and the result register are both updated
// in the accepting cycle, so the only loop is the state update of the byte decoder.
// s_axis_tready stays high while the result register is empty or is being
// taken in the same cycle; when the receiver stalls, the pending result holds
// and input is refused until it is taken.
// Reset empties the result register, clears the sequence state and sets both
// enables (space, tab) to 1. Configuration writes via cfg_we_i take effect at once.
// The user must make them only while no string is in progress; it is not enforced.
module utf8_text_validator_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Configuration write port
  input  logic                           cfg_we_i,
  input  logic [utv_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic                           cfg_data_i,
  // Input stream
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [7:0]                     s_axis_tdata,   // [7:0] text_byte
  input  logic                           s_axis_tlast,   // last_byte
  // Result stream
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [7:0]                     m_axis_tdata    // [1:0] verdict, [2] error_seen
);

  logic                 space_en_q;
  logic                 tab_en_q;
  utv_pkg::seq_state_t  state_q, state_d;
  utv_pkg::result_t     res_q, res_d;
  logic                 out_valid_q;
  logic                 in_fire;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      space_en_q <= 1'b1;
      tab_en_q   <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        utv_pkg::CFG_SPACE_EN: space_en_q <= cfg_data_i;
        utv_pkg::CFG_TAB_EN:   tab_en_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  utv_step u_step (
    .cur_i      (state_q),
    .byte_i     (s_axis_tdata),
    .last_i     (s_axis_tlast),
    .space_en_i (space_en_q),
    .tab_en_i   (tab_en_q),
    .nxt_o      (state_d),
    .res_o      (res_d)
  );

  // Sequence state advances on each accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (in_fire) begin
      state_q <= state_d;
    end
  end

  // Result register valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'd0, res_q.error_seen, res_q.verdict};

endmodule

### rtl/utv_chk.sv
// Port-level checker for the UTF-8 text validator, bound to the top level.
module utv_chk (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic       s_axis_tlast,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("result changed while stalled");

  // Every accepted item yields a result next cycle
  a_in_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> m_axis_tvalid)
    else $error("accepted item gave no result");

  // Input is never refused while the result register is empty
  a_ready_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input refused with empty result register");

  // Verdict and error flag agree; no unused verdict code
  a_verdict_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[1:0] != 2'd3) &&
                      ((m_axis_tdata[1:0] != 2'd2) || m_axis_tdata[2]) &&
                      ((m_axis_tdata[1:0] != 2'd1) || !m_axis_tdata[2]))
    else $error("verdict inconsistent with error flag");

  // A closing verdict only follows a last byte
  a_close_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=>
      ((m_axis_tdata[1:0] != 2'd0) == $past(s_axis_tlast)))
    else $error("verdict does not match last flag");

endmodule

bind utf8_text_validator_core utv_chk u_utv_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

### verif/tb_top.sv
// Self-checking testbench for utf8_text_validator_core: byte strings in, verdicts out.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import utv_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned PhaseNum   = 5;
  localparam int unsigned PhaseBytes = 345;
  localparam int unsigned HoldCycles = 400;

  // Directed strings: bit 8 marks the last byte of a string
  localparam int unsigned DirNum = 31;
  localparam logic [8:0] DIRECTED [DirNum] = '{
    9'h009, 9'h020, 9'h0F4, 9'h08F, 9'h0BF, 9'h1BF,  // tab, space, U+10FFFF: valid
    9'h100,                                          // NUL lead
    9'h17F,                                          // DEL lead
    9'h11F,                                          // control lead
    9'h180,                                          // bare continuation
    9'h0C1, 9'h1BF,                                  // two-byte overlong
    9'h1F8,                                          // lead 0xF8 and above
    9'h0C2, 9'h141,                                  // ASCII where a continuation is due
    9'h0E0, 9'h09F, 9'h1BF,                          // three-byte overlong
    9'h0ED, 9'h0A0, 9'h180,                          // surrogate
    9'h0F0, 9'h08F, 9'h0BF, 9'h1BF,                  // four-byte overlong
    9'h0F4, 9'h090, 9'h080, 9'h180,                  // above U+10FFFF
    9'h0E2, 9'h182                                   // sequence cut off by end of string
  };

  // Register settings per random phase
  localparam logic SPACE_PLAN [PhaseNum] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
  localparam logic TAB_PLAN   [PhaseNum] = '{1'b0, 1'b0, 1'b1, 1'b1, 1'b0};

  // Predicts the verdict stream and checks the block's results against it
  class utf8_verdict_predictor;
    logic           space_en;
    logic           tab_en;
    logic [1:0]     pending;
    logic [2:0]     seq_len;
    logic [CpW-1:0] cp;
    logic           err;
    result_t        expected_results[$];
    int unsigned    mismatch_count;
    int unsigned    bytes_checked;
    int unsigned    strings_valid;
    int unsigned    strings_invalid;

    function new();
      space_en        = 1'b1;
      tab_en          = 1'b1;
      err             = 1'b0;
      mismatch_count  = 0;
      bytes_checked   = 0;
      strings_valid   = 0;
      strings_invalid = 0;
      clear_sequence();
    endfunction

    function void clear_sequence();
      pending = 2'd0;
      seq_len = 3'd0;
      cp      = '0;
    endfunction

    function void mark_error();
      err = 1'b1;
      clear_sequence();
    endfunction

    function void set_flags(logic space, logic tab);
      space_en = space;
      tab_en   = tab;
    endfunction

    // Advance the decoder by one accepted byte and queue its result
    function void note_byte(logic [7:0] b, logic last);
      result_t        r;
      logic [CpW-1:0] nxt;
      if (!err && pending == 2'd0) begin
        if (b == BYTE_NUL || b == BYTE_DEL ||
            (b < BYTE_SPACE && !(tab_en && b == BYTE_TAB)) ||
            (!space_en && b == BYTE_SPACE)) begin
          mark_error();
        end else if (!b[7]) begin
          clear_sequence();
        end else if (b[7:5] == 3'b110) begin
          // 0xC0 and 0xC1 can only encode overlong forms
          if (b[4:1] == 4'd0) begin
            mark_error();
          end else begin
            seq_len = 3'd2;
            pending = 2'd1;
            cp      = {16'd0, b[4:0]};
          end
        end else if (b[7:4] == 4'b1110) begin
          seq_len = 3'd3;
          pending = 2'd2;
          cp      = {17'd0, b[3:0]};
        end else if (b[7:3] == 5'b11110) begin
          seq_len = 3'd4;
          pending = 2'd3;
          cp      = {18'd0, b[2:0]};
        end else begin
          mark_error();
        end
      end else if (!err) begin
        if (b[7:6] != 2'b10) begin
          mark_error();
        end else begin
          nxt     = {cp[CpW-7:0], b[5:0]};
          cp      = nxt;
          pending = pending - 2'd1;
          // Check the finished code point for overlong, surrogate and range
          if (pending == 2'd0) begin
            if ((seq_len == 3'd3 && nxt < CP_MIN_3B) ||
                (seq_len == 3'd4 && nxt < CP_MIN_4B) ||
                (nxt >= CP_SURR_LO && nxt <= CP_SURR_HI) ||
                nxt > CP_MAX) begin
              mark_error();
            end else begin
              clear_sequence();
            end
          end
        end
      end

      if (last) begin
        if (pending != 2'd0) begin
          mark_error();
        end
        r.verdict    = err ? VERDICT_INVALID : VERDICT_VALID;
        r.error_seen = err;
        if (err) begin
          strings_invalid++;
        end else begin
          strings_valid++;
        end
        clear_sequence();
        err = 1'b0;
      end else begin
        r.verdict    = VERDICT_OPEN;
        r.error_seen = err;
      end
      expected_results = {expected_results, r};
    endfunction

    task report_mismatch(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      mismatch_count++;
    endtask

    // Compare one accepted result with the oldest expectation
    task check_result(logic [7:0] data);
      result_t want;
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("result 0x%02h with nothing expected", data));
        return;
      end
      want = expected_results.pop_front();
      bytes_checked++;
      if (data[1:0] !== want.verdict) begin
        report_mismatch($sformatf("result %0d: verdict %0d, expected %s",
                                  bytes_checked, data[1:0], want.verdict.name()));
      end
      if (data[2] !== want.error_seen) begin
        report_mismatch($sformatf("result %0d: error_seen %0b, expected %0b",
                                  bytes_checked, data[2], want.error_seen));
      end
    endtask
  endclass

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i     = CFG_SPACE_EN;
  logic                cfg_data_i    = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata  = 8'h00;
  logic                s_axis_tlast  = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [7:0]          m_axis_tdata;

  utf8_verdict_predictor sb;
  logic [7:0]            text_q[$];
  int unsigned           phase_bytes;
  int unsigned           burst_left   = 0;
  logic                  tx_gaps_on   = 1'b1;
  logic                  rx_stalls_on = 1'b1;
  int unsigned           hold_request = 0;
  int unsigned           hold_left;
  int unsigned           rx_run_left  = 0;
  logic                  rx_open      = 1'b0;
  int unsigned           cycle_count  = 0;

  utf8_text_validator_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // End the run if it hangs
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("utf8_text_validator_core regression: fail");
      $finish;
    end
  end

  // Note accepted input items, then check accepted result items
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        sb.note_byte(s_axis_tdata, s_axis_tlast);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        sb.check_result(m_axis_tdata);
      end
    end
  end

  // Drive the result-side ready: free running, a stall pattern, or a long hold
  always begin
    @(posedge clk_i);
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
      m_axis_tready <= 1'b0;
      while (hold_left != 0) begin
        @(posedge clk_i);
        hold_left--;
      end
    end else if (!rx_stalls_on) begin
      m_axis_tready <= 1'b1;
    end else begin
      if (rx_run_left == 0) begin
        rx_open     = !rx_open;
        rx_run_left = rx_open ? $urandom_range(1, 12) : $urandom_range(1, 5);
      end
      rx_run_left--;
      m_axis_tready <= rx_open;
    end
  end

  // Offer one item, in bursts with random gaps, and hold it until accepted
  task automatic send_byte(input logic [7:0] b, input logic last);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = (!tx_gaps_on || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Append the UTF-8 encoding of a value in a chosen number of bytes
  task automatic push_code(input logic [20:0] val, input int nbytes);
    logic [7:0] lead;
    case (nbytes)
      2: begin
        lead = {3'b110, val[10:6]};
      end
      3: begin
        lead = {4'b1110, val[15:12]};
      end
      default: begin
        lead = {5'b11110, val[20:18]};
      end
    endcase
    text_q = {text_q, lead};
    for (int k = nbytes - 2; k >= 0; k--) begin
      text_q = {text_q, {2'b10, 6'(val >> (6 * k))}};
    end
  endtask

  // Build a random string, mostly well formed, and send it
  task automatic send_random_string();
    int unsigned nchars;
    int unsigned kind;
    int unsigned n;
    int unsigned cut;
    logic        clean;
    text_q.delete();
    nchars = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
    clean  = 1'($urandom_range(0, 1));
    for (int c = 0; c < nchars; c++) begin
      kind = clean ? $urandom_range(0, 63) : $urandom_range(0, 99);
      if (kind < 30) begin
        text_q = {text_q, 8'($urandom_range(8'h21, 8'h7E))};
      end else if (kind < 36) begin
        text_q = {text_q, ($urandom_range(0, 1) != 0) ? BYTE_SPACE : BYTE_TAB};
      end else if (kind < 50) begin
        push_code(21'($urandom_range(21'h80, 21'h7FF)), 2);
      end else if (kind < 64) begin
        push_code(21'($urandom_range(21'h800, 21'hFFFF)), 3);
      end else if (kind < 70) begin
        // around the surrogate range
        push_code(21'($urandom_range(21'hD7F0, 21'hE00F)), 3);
      end else if (kind < 80) begin
        push_code(21'($urandom_range(21'h10000, 21'h10FFFF)), 4);
      end else if (kind < 83) begin
        push_code(21'($urandom_range(21'h10FFF0, 21'h1FFFFF)), 4);
      end else if (kind < 87) begin
        // overlong: a value short enough for fewer bytes
        n = $urandom_range(2, 4);
        push_code(21'($urandom_range(0, (n == 2) ? 'h7F : (n == 3) ? 'h7FF : 'hFFFF)), n);
      end else if (kind < 91) begin
        text_q = {text_q, ($urandom_range(0, 3) == 0) ? BYTE_DEL
                                                       : 8'($urandom_range(0, 8'h1F))};
      end else if (kind < 95) begin
        // drop the tail of a multi-byte sequence
        n = $urandom_range(2, 4);
        push_code(21'($urandom_range(21'h80, 21'h10FFFF)), n);
        cut = $urandom_range(1, n - 1);
        repeat (cut) void'(text_q.pop_back());
      end else begin
        text_q = {text_q, 8'($urandom_range(0, 255))};
      end
    end
    foreach (text_q[k]) begin
      send_byte(text_q[k], k == text_q.size() - 1);
    end
    phase_bytes += text_q.size();
  endtask

  // Stop offering and wait until every result has been checked
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_results.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  initial begin
    sb = new();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed strings at the reset settings
    for (int i = 0; i < DirNum; i++) begin
      send_byte(DIRECTED[i][7:0], DIRECTED[i][8]);
    end

    // Random phases, each under its own register settings
    for (int p = 0; p < PhaseNum; p++) begin
      wait_idle();
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= CFG_SPACE_EN;
      cfg_data_i <= SPACE_PLAN[p];
      @(posedge clk_i);
      cfg_idx_i  <= CFG_TAB_EN;
      cfg_data_i <= TAB_PLAN[p];
      @(posedge clk_i);
      cfg_we_i   <= 1'b0;
      sb.set_flags(SPACE_PLAN[p], TAB_PLAN[p]);
      tx_gaps_on   = (p != 1);
      rx_stalls_on = (p != 1);
      if (p == 0) begin
        hold_request = HoldCycles;
      end
      phase_bytes = 0;
      while (phase_bytes < PhaseBytes) begin
        send_random_string();
      end
    end

    wait_idle();
    $display("checked %0d result items over %0d strings (%0d valid, %0d invalid)",
             sb.bytes_checked, sb.strings_valid + sb.strings_invalid,
             sb.strings_valid, sb.strings_invalid);
    $display("all four space/tab settings, a long result hold-off, %0d mismatches",
             sb.mismatch_count);
    if (sb.mismatch_count == 0) begin
      $display("utf8_text_validator_core regression: pass");
    end else begin
      $display("utf8_text_validator_core regression: fail");
    end
    $finish;
  end

endmodule
